FILE: rtl/nic_pkg.sv
// nic_pkg: shared types, constants and the CRC-32C byte update for the
// node ID / address check. No dependencies; imported by every RTL file but nic_if.
`default_nettype none

package nic_pkg;

  // Build-time default for IPv6 support
  localparam bit NIC_SUPPORT_IPV6 = 1'b1;

  // CRC-32C, reflected form
  localparam logic [31:0] CRC_POLY = 32'h82F63B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Per-octet address masks, first octet in the top byte
  localparam logic [31:0] V4_MASK = 32'h030F3FFF;
  localparam logic [63:0] V6_MASK = 64'h0103070F1F3F7FFF;

  // Identifier bits compared against the hash (top 21 bits)
  localparam int unsigned ID_CMP_W = 21;

  // One input item
  typedef struct packed {
    logic        is_ipv6;
    logic [31:0] ipv4_address;
    logic [63:0] ipv6_prefix;
    logic [7:0]  id_byte0;
    logic [7:0]  id_byte1;
    logic [7:0]  id_byte2;
    logic [7:0]  id_byte19;
  } in_t;

  // Between the two CRC halves
  typedef struct packed {
    logic                unsup;
    logic                is_ipv6;
    logic [31:0]         crc;
    logic [31:0]         tail;
    logic [ID_CMP_W-1:0] id_bits;
  } mid_t;

  // One result item
  typedef struct packed {
    logic        id_valid;
    logic [31:0] prefix_hash;
    logic        unsupported;
  } res_t;

  // One octet through the reflected CRC register, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/nic_if.sv
// nic_if: valid/ready channel interfaces for the address check input and
// result streams. Depends on nothing.
`default_nettype none

interface nic_in_if;
  logic        valid;
  logic        ready;
  logic        is_ipv6;
  logic [31:0] ipv4_address;
  logic [63:0] ipv6_prefix;
  logic [7:0]  id_byte0;
  logic [7:0]  id_byte1;
  logic [7:0]  id_byte2;
  logic [7:0]  id_byte19;

  modport source (
    output valid, is_ipv6, ipv4_address, ipv6_prefix,
           id_byte0, id_byte1, id_byte2, id_byte19,
    input  ready
  );
  modport sink (
    input  valid, is_ipv6, ipv4_address, ipv6_prefix,
           id_byte0, id_byte1, id_byte2, id_byte19,
    output ready
  );
endinterface

interface nic_out_if;
  logic        valid;
  logic        ready;
  logic        id_valid;
  logic [31:0] prefix_hash;
  logic        unsupported;

  modport source (output valid, id_valid, prefix_hash, unsupported, input ready);
  modport sink   (input valid, id_valid, prefix_hash, unsupported, output ready);
endinterface

`default_nettype wire

FILE: rtl/nic_front.sv
// nic_front: masks and seeds the address octets and runs the CRC over the
// first four of them. Depends on nic_pkg.
`default_nettype none

module nic_front import nic_pkg::*; #(
  parameter bit SUPPORT_IPV6 = NIC_SUPPORT_IPV6
) (
  input  in_t  item,
  output mid_t mid
);

  logic [63:0] oct;
  logic [31:0] crc;

  // Masked octets, IPv4 left-aligned in the top word
  always_comb begin
    if (item.is_ipv6) begin
      oct = item.ipv6_prefix & V6_MASK;
    end else begin
      oct = {item.ipv4_address & V4_MASK, 32'h0};
    end
    // seed into bits 7..5 of the first octet
    oct[63:61] = oct[63:61] | item.id_byte19[2:0];
  end

  // First four octets, first octet first
  always_comb begin
    crc = CRC_INIT;
    for (int i = 0; i < 4; i++) begin
      crc = crc_byte(crc, oct[63-8*i -: 8]);
    end
  end

  assign mid.unsup   = item.is_ipv6 & ~SUPPORT_IPV6;
  assign mid.is_ipv6 = item.is_ipv6;
  assign mid.crc     = crc;
  assign mid.tail    = oct[31:0];
  assign mid.id_bits = {item.id_byte0, item.id_byte1, item.id_byte2[7:3]};

endmodule

`default_nettype wire

FILE: rtl/nic_back.sv
// nic_back: finishes the CRC over the last four IPv6 octets, complements it
// and compares against the identifier bits. Depends on nic_pkg.
`default_nettype none

module nic_back import nic_pkg::*; (
  input  mid_t mid,
  output res_t res
);

  logic [31:0] crc;
  logic [31:0] hash;

  // Remaining octets only for IPv6
  always_comb begin
    crc = mid.crc;
    if (mid.is_ipv6) begin
      for (int i = 0; i < 4; i++) begin
        crc = crc_byte(crc, mid.tail[31-8*i -: 8]);
      end
    end
  end

  assign hash = ~crc;

  // Result; an unsupported item reports zeros with the flag set
  always_comb begin
    if (mid.unsup) begin
      res.id_valid    = 1'b0;
      res.prefix_hash = 32'h0;
      res.unsupported = 1'b1;
    end else begin
      res.id_valid    = (mid.id_bits == hash[31:32-ID_CMP_W]);
      res.prefix_hash = hash;
      res.unsupported = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/node_id_ip_check.sv
// node_id_ip_check: checks that a node identifier is bound to its address.
// Channels: in_ch (sink) takes one address plus identifier bytes per
// transfer; out_ch (source) returns id_valid, the 32-bit CRC-32C hash and
// an unsupported flag, one result per input, in order.
// Pipeline: input register, mid register after the first four octets of
// CRC, result register after the last four octets and the compare.
// Throughput: one item per cycle unless out_ch.ready stalls the pipe; each stage holds one item and the
// per-stage CRC logic over four octets sets the clock path.
// Stall: when out_ch.ready is low the result register holds; earlier
// stages keep filling until all three are full, then in_ch.ready drops.
// in_ch.ready depends combinationally on out_ch.ready.
// Reset: synchronous rst_n clears all stage valid flags; no other state.
// SUPPORT_IPV6 = 0 makes IPv6 items return id_valid 0, hash 0,
// unsupported 1.
// Depends on nic_pkg, nic_if, nic_front, nic_back.
`default_nettype none

module node_id_ip_check import nic_pkg::*; #(
  parameter bit SUPPORT_IPV6 = NIC_SUPPORT_IPV6
) (
  input  logic clk,
  input  logic rst_n,
  nic_in_if.sink    in_ch,
  nic_out_if.source out_ch
);

  logic s0_v_r, s1_v_r, s2_v_r;
  in_t  s0_r;
  mid_t s1_r, mid_nxt;
  res_t s2_r, res_nxt;
  in_t  in_item;
  logic ld0, ld1, ld2;

  // Stage load enables; a stage loads when empty or emptying
  assign ld2 = ~s2_v_r | out_ch.ready;
  assign ld1 = ~s1_v_r | ld2;
  assign ld0 = ~s0_v_r | ld1;
  assign in_ch.ready = ld0;

  assign in_item.is_ipv6      = in_ch.is_ipv6;
  assign in_item.ipv4_address = in_ch.ipv4_address;
  assign in_item.ipv6_prefix  = in_ch.ipv6_prefix;
  assign in_item.id_byte0     = in_ch.id_byte0;
  assign in_item.id_byte1     = in_ch.id_byte1;
  assign in_item.id_byte2     = in_ch.id_byte2;
  assign in_item.id_byte19    = in_ch.id_byte19;

  nic_front #(.SUPPORT_IPV6(SUPPORT_IPV6)) u_front (
    .item (s0_r),
    .mid  (mid_nxt)
  );

  nic_back u_back (
    .mid (s1_r),
    .res (res_nxt)
  );

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (ld0) s0_v_r <= in_ch.valid;
      if (ld1) s1_v_r <= s0_v_r;
      if (ld2) s2_v_r <= s1_v_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ld0) s0_r <= in_item;
    if (ld1) s1_r <= mid_nxt;
    if (ld2) s2_r <= res_nxt;
  end

  assign out_ch.valid       = s2_v_r;
  assign out_ch.id_valid    = s2_r.id_valid;
  assign out_ch.prefix_hash = s2_r.prefix_hash;
  assign out_ch.unsupported = s2_r.unsupported;

  // Unsupported results carry no hash and never validate
  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_r.unsupported) |-> (!s2_r.id_valid && s2_r.prefix_hash == 32'h0))
    else $error("unsupported result carries hash or valid");

  // Unsupported flag only when IPv6 is built out
  a_unsup_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (!s2_r.unsupported || !SUPPORT_IPV6))
    else $error("unsupported flag with IPv6 enabled");

  // Input stalls only when the whole pipe is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s0_v_r && s1_v_r && s2_v_r))
    else $error("input stalled with an empty stage");

  // A blocked mid item is not lost
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !ld2) |=> s1_v_r)
    else $error("mid stage dropped an item");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// tb_top: self-checking testbench for node_id_ip_check (node ID / address binding).
// Depends on rtl/nic_pkg.sv, rtl/nic_if.sv and the node_id_ip_check RTL.
`timescale 1ns / 100ps

module tb_top;
  import nic_pkg::*;

  localparam bit TB_IPV6   = 1'b1;   // build choice passed to the DUT
  localparam int PIPE_LAT  = 3;      // cycles from input transfer to result
  localparam int CLK_HALF  = 10;

  logic clk;
  logic rst_n;

  nic_in_if  in_bus ();
  nic_out_if out_bus ();

  node_id_ip_check #(.SUPPORT_IPV6(TB_IPV6)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Expected results, oldest first
  res_t exp_results[$];

  int   src_idle_pct;
  int   sink_stall_pct;
  bit   hold_on;
  int   n_errors;
  int   n_sent;
  int   n_checked;
  int   n_bound;
  int   n_v6;

  // Clock
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what);
    n_errors++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // CRC-32C over the masked, seeded address octets and the ID compare
  function automatic res_t predict_binding(input in_t it);
    logic [7:0]  oct [8];
    logic [31:0] crc;
    int          n_oct;
    res_t        r;
    r = '0;
    if (it.is_ipv6 && !TB_IPV6) begin
      r.unsupported = 1'b1;
      return r;
    end
    if (it.is_ipv6) begin
      n_oct = 8;
      for (int i = 0; i < 8; i++)
        oct[i] = it.ipv6_prefix[63-8*i -: 8] & V6_MASK[63-8*i -: 8];
    end else begin
      n_oct = 4;
      for (int i = 0; i < 4; i++)
        oct[i] = it.ipv4_address[31-8*i -: 8] & V4_MASK[31-8*i -: 8];
    end
    oct[0] = oct[0] | {it.id_byte19[2:0], 5'b0};
    crc = 32'hFFFF_FFFF;
    for (int i = 0; i < n_oct; i++) begin
      crc = crc ^ {24'h0, oct[i]};
      for (int b = 0; b < 8; b++)
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    r.prefix_hash = ~crc;
    r.id_valid    = ({it.id_byte0, it.id_byte1, it.id_byte2[7:3]} == r.prefix_hash[31:11]);
    return r;
  endfunction

  // Rewrite the ID bytes so they match the hash; low bits of byte 2 untouched
  function automatic in_t bind_id(input in_t it);
    res_t r;
    r = predict_binding(it);
    it.id_byte0 = r.prefix_hash[31:24];
    it.id_byte1 = r.prefix_hash[23:16];
    it.id_byte2 = {r.prefix_hash[15:11], it.id_byte2[2:0]};
    return it;
  endfunction

  // Flip one of the 21 compared ID bits
  function automatic in_t near_miss(input in_t it, input int bit_pos);
    logic [20:0] idb;
    idb = {it.id_byte0, it.id_byte1, it.id_byte2[7:3]} ^ (21'd1 << bit_pos);
    it.id_byte0 = idb[20:13];
    it.id_byte1 = idb[12:5];
    it.id_byte2 = {idb[4:0], it.id_byte2[2:0]};
    return it;
  endfunction

  function automatic in_t mk_item(input logic is6, input logic [31:0] v4,
                                  input logic [63:0] v6, input logic [7:0] b19);
    in_t it;
    it = '0;
    it.is_ipv6      = is6;
    it.ipv4_address = v4;
    it.ipv6_prefix  = v6;
    it.id_byte19    = b19;
    return it;
  endfunction

  // Random item: half bound IDs, some near misses, the rest noise
  function automatic in_t gen_item();
    in_t it;
    int  pick;
    it.is_ipv6      = 1'($urandom_range(1));
    it.ipv4_address = $urandom;
    it.ipv6_prefix  = {$urandom, $urandom};
    it.id_byte0     = 8'($urandom);
    it.id_byte1     = 8'($urandom);
    it.id_byte2     = 8'($urandom);
    it.id_byte19    = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 5)       it.ipv4_address = '1;
    else if (pick < 10) it.ipv6_prefix  = '0;
    pick = $urandom_range(99);
    if (pick < 50)      it = bind_id(it);
    else if (pick < 65) it = near_miss(bind_id(it), $urandom_range(20));
    return it;
  endfunction

  // Offer one item, wait for its transfer, record the expected result
  task automatic send_lookup(input in_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.is_ipv6      <= it.is_ipv6;
    in_bus.ipv4_address <= it.ipv4_address;
    in_bus.ipv6_prefix  <= it.ipv6_prefix;
    in_bus.id_byte0     <= it.id_byte0;
    in_bus.id_byte1     <= it.id_byte1;
    in_bus.id_byte2     <= it.id_byte2;
    in_bus.id_byte19    <= it.id_byte19;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    exp_results.push_back(predict_binding(it));
    n_sent++;
    if (it.is_ipv6) n_v6++;
    @(negedge clk);
  endtask

  // Result-side ready: random stalls, or held low during a hold-off
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= !hold_on && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Hold-off counter, runs on its own
  task automatic hold_results(input int cycles);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_on = 1'b0;
  endtask

  // Result checker
  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (exp_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, hash %08h",
                                  out_bus.prefix_hash));
      end else begin
        exp_r = exp_results.pop_front();
        n_checked++;
        if (exp_r.id_valid) n_bound++;
        if (out_bus.id_valid !== exp_r.id_valid)
          report_mismatch($sformatf("id_valid got %0b want %0b (result %0d)",
                                    out_bus.id_valid, exp_r.id_valid, n_checked));
        if (out_bus.prefix_hash !== exp_r.prefix_hash)
          report_mismatch($sformatf("prefix_hash got %08h want %08h (result %0d)",
                                    out_bus.prefix_hash, exp_r.prefix_hash, n_checked));
        if (out_bus.unsupported !== exp_r.unsupported)
          report_mismatch($sformatf("unsupported got %0b want %0b (result %0d)",
                                    out_bus.unsupported, exp_r.unsupported, n_checked));
      end
    end
  end

  // Extremes, every seed, ignored fields and bits, near misses
  task automatic test_directed();
    in_t base;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_lookup(mk_item(1'b0, 32'h0000_0000, '1, 8'h00));
    send_lookup(mk_item(1'b0, 32'hFFFF_FFFF, '0, 8'hFF));
    send_lookup(mk_item(1'b1, 32'hFFFF_FFFF, '0, 8'h00));
    send_lookup(mk_item(1'b1, 32'h0000_0000, '1, 8'hFF));
    for (int s = 0; s < 8; s++) begin
      base = mk_item(1'b0, 32'hC0A8_0101, 64'h2001_0DB8_0000_0001, 8'(s));
      base.id_byte2 = 8'h07;
      send_lookup(bind_id(base));
    end
    base = bind_id(mk_item(1'b1, 32'h0A00_0001, 64'h2A02_1234_5678_9ABC, 8'h05));
    send_lookup(base);
    // upper seed bits take no part: same ID still matches
    base.id_byte19 = 8'hFD;
    send_lookup(base);
    // low bits of byte 2 are not compared
    base.id_byte2 = base.id_byte2 ^ 8'h07;
    send_lookup(base);
    // a single flipped bit in each compared byte breaks the match
    send_lookup(near_miss(base, 20));
    send_lookup(near_miss(base, 12));
    send_lookup(near_miss(base, 4));
    send_lookup(near_miss(base, 0));
    base = bind_id(mk_item(1'b0, 32'hFFFF_FFFF, '0, 8'h07));
    send_lookup(base);
    base.ipv6_prefix = '1;
    send_lookup(base);
  endtask

  task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (n) send_lookup(gen_item());
  endtask

  // Long result hold-off while the sender keeps offering, so the pipe fills
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    fork
      hold_results(150);
    join_none
    repeat (60) send_lookup(gen_item());
  endtask

  // Main sequence
  initial begin
    int guard;
    n_errors  = 0;
    n_sent    = 0;
    n_checked = 0;
    n_bound   = 0;
    n_v6      = 0;
    hold_on   = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    in_bus.valid        = 1'b0;
    in_bus.is_ipv6      = 1'b0;
    in_bus.ipv4_address = '0;
    in_bus.ipv6_prefix  = '0;
    in_bus.id_byte0     = '0;
    in_bus.id_byte1     = '0;
    in_bus.id_byte2     = '0;
    in_bus.id_byte19    = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_phase(300, 0, 0);
    test_random_phase(300, 79, 0);
    test_random_phase(300, 0, 79);
    test_random_phase(300, 8, 8);
    test_backpressure();

    // drain: stop offering, let every result out
    in_bus.valid  <= 1'b0;
    sink_stall_pct = 0;
    guard = 0;
    while (exp_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (exp_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", exp_results.size()));

    $display("Run covered %0d transfers in (%0d IPv6), %0d results checked, %0d bound IDs.",
             n_sent, n_v6, n_checked, n_bound);
    $display("Phases: directed, free-running, sender gaps, result stalls, both, long hold-off.");
    if (n_errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #(64'd4_000_000);
    $display("Timeout waiting on the DUT.");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
rtl/nic_pkg.sv
rtl/nic_if.sv
rtl/nic_front.sv
rtl/nic_back.sv
rtl/node_id_ip_check.sv
dv/tb_top.sv
